// File: rtl/core/lsog_pkg.sv
// Shared types, constants and sine table generator for the occupancy grid hit update core.
package lsog_pkg;

  localparam int RANGE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int INDEX_W   = 13;
  localparam int VALUE_W   = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET    = 3'd5;

  localparam logic [CFG_W-1:0] RANGE_MIN_RST   = 16'd0;
  localparam logic [CFG_W-1:0] RANGE_MAX_RST   = 16'd65535;
  localparam logic [CFG_W-1:0] ANGLE_START_RST = 16'd0;
  localparam logic [CFG_W-1:0] ANGLE_STEP_RST  = 16'd0;
  localparam logic [CFG_W-1:0] X_OFFSET_RST    = 16'd256;
  localparam logic [CFG_W-1:0] Y_OFFSET_RST    = 16'd1280;

  localparam logic signed [VALUE_W-1:0] CELL_UNKNOWN = -8'sd1;
  localparam logic signed [VALUE_W-1:0] CELL_MAX     = 8'sd100;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic                      cell_written;
    logic                      out_of_map;
    logic [INDEX_W-1:0]        cell_index;
    logic signed [VALUE_W-1:0] cell_value;
  } res_t;

  // Q30 Taylor series of sine, rounded to Q1.15 and saturated; elaboration only
  function automatic logic [14:0] sine_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;   sum = sum - term;
    term = ((term * x2) >> 30) / 20;  sum = sum + term;
    term = ((term * x2) >> 30) / 42;  sum = sum - term;
    term = ((term * x2) >> 30) / 72;  sum = sum + term;
    term = ((term * x2) >> 30) / 110; sum = sum - term;
    term = ((term * x2) >> 30) / 156; sum = sum + term;
    term = ((term * x2) >> 30) / 210; sum = sum - term;
    term = ((term * x2) >> 30) / 272; sum = sum + term;
    term = ((term * x2) >> 30) / 342; sum = sum - term;
    term = ((term * x2) >> 30) / 420; sum = sum + term;
    term = ((term * x2) >> 30) / 506; sum = sum - term;
    term = ((term * x2) >> 30) / 600; sum = sum + term;
    r = (sum + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

endpackage

// File: rtl/core/lsog_if.sv
// Stream interfaces for range readings in and cell update results out.
interface lsog_in_if;
  import lsog_pkg::*;
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_sample;
  logic               scan_start;

  modport source (output valid, output range_sample, output scan_start, input ready);
  modport sink   (input valid, input range_sample, input scan_start, output ready);
endinterface

interface lsog_out_if;
  import lsog_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      cell_written;
  logic                      out_of_map;
  logic [INDEX_W-1:0]        cell_index;
  logic signed [VALUE_W-1:0] cell_value;

  modport source (output valid, output cell_written, output out_of_map,
                  output cell_index, output cell_value, input ready);
  modport sink   (input valid, input cell_written, input out_of_map,
                  input cell_index, input cell_value, output ready);
endinterface

// File: rtl/core/laser_scan_occupancy_grid_update_core.sv
// Each accepted reading runs through the registered stages below into the output queue.
// Throughput: one reading per cycle while pipeline and queue hold under eight words; the
// map lives in one single-port-write memory, read and incremented for each word, written
// back on a hit, with forwarding of the last write. Reset: synchronous, active low; then a
// clearing pass writes unknown to every map cell, during which in_ready stays low.
module laser_scan_occupancy_grid_update_core #(
  parameter int GRID_ROWS       = 64,
  parameter int GRID_COLS       = 128,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lsog_in_if.sink                        in_ch,
  lsog_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [lsog_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lsog_pkg::CFG_W-1:0]     cfg_wdata
);
  import lsog_pkg::*;

  localparam int MAP_CELLS  = GRID_ROWS * GRID_COLS;
  localparam int CELL_W     = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
  localparam int RW         = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW         = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int SB         = SINE_TABLE_BITS;
  localparam int SINE_Q     = 1 << (SB - 2);
  localparam int QW         = SB - 1;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = 3;
  localparam int OCC_W      = 4;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] range_min_r, range_max_r, angle_start_r, angle_step_r;
  logic [CFG_W-1:0] x_offset_r, y_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r   <= RANGE_MIN_RST;
      range_max_r   <= RANGE_MAX_RST;
      angle_start_r <= ANGLE_START_RST;
      angle_step_r  <= ANGLE_STEP_RST;
      x_offset_r    <= X_OFFSET_RST;
      y_offset_r    <= Y_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RANGE_MIN:   range_min_r   <= cfg_wdata;
        REG_RANGE_MAX:   range_max_r   <= cfg_wdata;
        REG_ANGLE_START: angle_start_r <= cfg_wdata;
        REG_ANGLE_STEP:  angle_step_r  <= cfg_wdata;
        REG_X_OFFSET:    x_offset_r    <= cfg_wdata;
        REG_Y_OFFSET:    y_offset_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- sine table ----------------
  logic [14:0] sine_rom [SINE_Q+1];

  for (genvar k = 0; k <= SINE_Q; k++) begin : g_rom
    localparam logic [63:0] XK = (64'(k) * HALF_PI_Q30 + 64'(SINE_Q / 2)) / 64'(SINE_Q);
    assign sine_rom[k] = sine_q15(XK);
  end

  // ---------------- flow control ----------------
  logic             clearing_r;
  logic [CELL_W-1:0] clr_cnt_r;
  logic [OCC_W-1:0] occ_r;
  logic             in_fire, out_fire;

  assign in_ch.ready = !clearing_r && (occ_r < OCC_W'(FIFO_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;

  // ---------------- stage 0 -> 1: angle and range window ----------------
  logic [15:0] cnt_r;
  logic [15:0] cnt_cur;
  logic [31:0] step_prod;
  logic [15:0] angle_nxt;
  logic        v1_r, inr1_r;
  logic [15:0] angle1_r, range1_r;

  assign cnt_cur   = in_ch.scan_start ? 16'd0 : cnt_r;
  assign step_prod = cnt_cur * angle_step_r;
  assign angle_nxt = angle_start_r + step_prod[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 16'd0;
      v1_r  <= 1'b0;
    end else begin
      v1_r <= in_fire;
      if (in_fire) begin
        cnt_r <= cnt_cur + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    angle1_r <= angle_nxt;
    range1_r <= in_ch.range_sample;
    inr1_r   <= (in_ch.range_sample > range_min_r) && (in_ch.range_sample < range_max_r);
  end

  // ---------------- stage 1 -> 2: quadrant fold and table read ----------------
  logic [SB-1:0]  sidx;
  logic [1:0]     s_quad, c_quad;
  logic [SB-3:0]  s_rem;
  logic [QW-1:0]  s_addr, c_addr;
  logic           v2_r, inr2_r, sneg2_r, cneg2_r;
  logic [14:0]    smag2_r, cmag2_r;
  logic [15:0]    range2_r;

  assign sidx   = angle1_r[15 -: SB];
  assign s_quad = sidx[SB-1:SB-2];
  assign s_rem  = sidx[SB-3:0];
  assign c_quad = s_quad + 2'd1;  // a quarter turn further on
  assign s_addr = s_quad[0] ? (QW'(SINE_Q) - {1'b0, s_rem}) : {1'b0, s_rem};
  assign c_addr = c_quad[0] ? (QW'(SINE_Q) - {1'b0, s_rem}) : {1'b0, s_rem};

  always_ff @(posedge clk) begin
    smag2_r  <= sine_rom[s_addr];
    cmag2_r  <= sine_rom[c_addr];
    sneg2_r  <= s_quad[1];
    cneg2_r  <= c_quad[1];
    range2_r <= range1_r;
    inr2_r   <= inr1_r;
  end

  // ---------------- stage 2 -> 3: products ----------------
  logic        v3_r, inr3_r, sneg3_r, cneg3_r;
  logic [30:0] sprod3_r, cprod3_r;

  always_ff @(posedge clk) begin
    sprod3_r <= smag2_r * range2_r;
    cprod3_r <= cmag2_r * range2_r;
    sneg3_r  <= sneg2_r;
    cneg3_r  <= cneg2_r;
    inr3_r   <= inr2_r;
  end

  // ---------------- stage 3 -> 4: sign and offset, Q.23 ----------------
  logic signed [33:0] sterm, cterm, xoff, yoff;
  logic signed [33:0] racc4_r, cacc4_r;
  logic               v4_r, inr4_r;

  assign sterm = sneg3_r ? -$signed({3'b0, sprod3_r}) : $signed({3'b0, sprod3_r});
  assign cterm = cneg3_r ? -$signed({3'b0, cprod3_r}) : $signed({3'b0, cprod3_r});
  assign xoff  = $signed({{3{x_offset_r[15]}}, x_offset_r, 15'b0});
  assign yoff  = $signed({{3{y_offset_r[15]}}, y_offset_r, 15'b0});

  always_ff @(posedge clk) begin
    racc4_r <= sterm + xoff;
    cacc4_r <= cterm + yoff;
    inr4_r  <= inr3_r;
  end

  // ---------------- stage 4 -> 5: truncate toward zero, bounds ----------------
  logic signed [33:0] rtq, ctq;
  logic [11:0]        row_q, col_q;
  logic               row_ok, col_ok;
  logic               v5_r, inr5_r, inmap5_r;
  logic [RW-1:0]      row5_r;
  logic [CW-1:0]      col5_r;

  assign rtq    = (racc4_r + (racc4_r[33] ? 34'sd8388607 : 34'sd0)) >>> 23;
  assign ctq    = (cacc4_r + (cacc4_r[33] ? 34'sd8388607 : 34'sd0)) >>> 23;
  assign row_q  = rtq[11:0];
  assign col_q  = ctq[11:0];
  assign row_ok = !row_q[11] && (row_q[10:0] < 11'(GRID_ROWS));
  assign col_ok = !col_q[11] && (col_q[10:0] < 11'(GRID_COLS));

  always_ff @(posedge clk) begin
    row5_r   <= row_q[RW-1:0];
    col5_r   <= col_q[CW-1:0];
    inmap5_r <= row_ok && col_ok;
    inr5_r   <= inr4_r;
  end

  // ---------------- stage 5 -> 6: map read ----------------
  logic signed [VALUE_W-1:0] map_mem [MAP_CELLS];
  logic signed [VALUE_W-1:0] mem_q_r;
  logic [CELL_W-1:0]         rd_addr, addr6_r;
  logic                      v6_r, inr6_r, inmap6_r;

  assign rd_addr = CELL_W'(row5_r) * CELL_W'(GRID_COLS) + CELL_W'(col5_r);

  always_ff @(posedge clk) begin
    addr6_r  <= rd_addr;
    inr6_r   <= inr5_r;
    inmap6_r <= inmap5_r;
  end

  // ---------------- stage 6: modify, write back, queue result ----------------
  logic                      upd_we;
  logic signed [VALUE_W-1:0] old_val, new_val;
  logic signed [8:0]         sum9;
  logic                      wr_en_r;
  logic [CELL_W-1:0]         wr_addr_r;
  logic signed [VALUE_W-1:0] wr_val_r;
  res_t                      res;

  assign upd_we  = v6_r && inr6_r && inmap6_r;
  // the word directly ahead wrote at the edge where this word's read was taken
  assign old_val = (wr_en_r && (wr_addr_r == addr6_r)) ? wr_val_r : mem_q_r;
  assign sum9    = $signed({old_val[7], old_val}) + 9'sd1;

  always_comb begin
    if (sum9 > 9'sd100) begin
      new_val = CELL_MAX;
    end else if (sum9 < 9'sd0) begin
      new_val = 8'sd0;
    end else begin
      new_val = sum9[7:0];
    end
  end

  always_comb begin
    logic [CELL_W+INDEX_W-1:0] idx_ext;
    idx_ext          = {{INDEX_W{1'b0}}, addr6_r};
    res.cell_written = upd_we;
    res.out_of_map   = inr6_r && !inmap6_r;
    res.cell_index   = upd_we ? idx_ext[INDEX_W-1:0] : '0;
    res.cell_value   = upd_we ? new_val : 8'sd0;
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      map_mem[clr_cnt_r] <= CELL_UNKNOWN;
    end else if (upd_we) begin
      map_mem[addr6_r] <= new_val;
    end
    mem_q_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= addr6_r;
    wr_val_r  <= new_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      v6_r       <= 1'b0;
      wr_en_r    <= 1'b0;
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      wr_en_r <= upd_we;
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + CELL_W'(1);
        if (clr_cnt_r == CELL_W'(MAP_CELLS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  // ---------------- output queue ----------------
  res_t             fifo_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OCC_W-1:0] fifo_cnt_r;
  res_t             head;

  assign head              = fifo_mem[rd_ptr_r];
  assign out_ch.valid      = (fifo_cnt_r != '0);
  assign out_ch.cell_written = head.cell_written;
  assign out_ch.out_of_map = head.out_of_map;
  assign out_ch.cell_index = head.cell_index;
  assign out_ch.cell_value = head.cell_value;
  assign out_fire          = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (v6_r) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      occ_r      <= '0;
    end else begin
      if (v6_r) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_r + OCC_W'(v6_r) - OCC_W'(out_fire);
      // words accepted and not yet delivered, pipeline and queue together
      occ_r      <= occ_r + OCC_W'(in_fire) - OCC_W'(out_fire);
    end
  end

endmodule

// File: tb/lsog_checker.sv
// Checker for the occupancy grid core: shadows map, counter and registers, predicts every word.
module lsog_checker #(
  parameter int ROWS      = 64,
  parameter int COLS      = 128,
  parameter int SINE_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  lsog_in_if                             in_mon,
  lsog_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [lsog_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lsog_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             errors,
  output int                             pending,
  output int                             cells_hit,
  output int                             off_grid,
  output int                             out_of_window,
  output int                             at_ceiling
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsog_pkg::*;

  localparam int CELLS   = ROWS * COLS;
  localparam int WAVE_N  = 1 << SINE_BITS;
  localparam int QUARTER = WAVE_N / 4;

  int                        quarter_wave [QUARTER + 1];
  logic signed [VALUE_W-1:0] grid [CELLS];
  logic [15:0]               beam_count;
  logic [CFG_W-1:0]          win_lo, win_hi, ang_base, ang_incr, row_bias, col_bias;
  res_t                      expected_q [$];
  int                        n_err, n_hit, n_off, n_skip, n_ceil;

  // Q30 Taylor series over one quarter turn, rounded to Q1.15
  function automatic int quarter_sine_q15(input int k);
    longint unsigned x, x2, term, acc;
    int n;
    x    = (longint'(k) * HALF_PI_Q30 + QUARTER / 2) / QUARTER;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / longint'(2 * n * (2 * n + 1));
      acc  = (n % 2 == 1) ? acc - term : acc + term;
    end
    acc = (acc + 64'd16384) >> 15;
    return (acc > 64'd32767) ? 32767 : int'(acc);
  endfunction

  function automatic int sine_lookup(input int unsigned idx);
    int unsigned i, pos;
    i   = idx & (WAVE_N - 1);
    pos = i % QUARTER;
    case (i / QUARTER)
      0:       return quarter_wave[pos];
      1:       return quarter_wave[QUARTER - pos];
      2:       return -quarter_wave[pos];
      default: return -quarter_wave[QUARTER - pos];
    endcase
  endfunction

  // trig(Q1.15) * range(Q8.8) + offset(Q8.8) in Q.23, truncated toward zero
  function automatic longint grid_coord(input int trig, input logic [15:0] rng,
                                        input logic [15:0] bias);
    longint acc;
    acc = longint'(trig) * longint'(rng) + longint'($signed(bias)) * 64'sd32768;
    return acc / 64'sd8388608;
  endfunction

  function automatic res_t predict_reading(input logic [15:0] rng, input logic first);
    logic [15:0] cnt, ang;
    int unsigned sidx;
    longint      row, col;
    int          cell_no, v;
    res_t        r;
    if (first) begin
      beam_count = '0;
    end
    cnt        = beam_count;
    beam_count = beam_count + 16'd1;
    r          = '0;
    if (!(rng > win_lo && rng < win_hi)) begin
      n_skip++;
      return r;
    end
    ang  = ang_base + cnt * ang_incr;
    sidx = ang >> (16 - SINE_BITS);
    row  = grid_coord(sine_lookup(sidx), rng, row_bias);
    col  = grid_coord(sine_lookup(sidx + QUARTER), rng, col_bias);
    if (row < 0 || row >= ROWS || col < 0 || col >= COLS) begin
      r.out_of_map = 1'b1;
      n_off++;
      return r;
    end
    cell_no = int'(row) * COLS + int'(col);
    v       = int'(grid[cell_no]) + 1;
    if (v > CELL_MAX) begin
      v = CELL_MAX;
      n_ceil++;
    end
    if (v < 0) begin
      v = 0;
    end
    grid[cell_no]  = v[VALUE_W-1:0];
    r.cell_written = 1'b1;
    r.cell_index   = cell_no[INDEX_W-1:0];
    r.cell_value   = v[VALUE_W-1:0];
    n_hit++;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_err++;
    end
  endtask

  initial begin
    int k;
    for (k = 0; k <= QUARTER; k++) begin
      quarter_wave[k] = quarter_sine_q15(k);
    end
  end

  always @(posedge clk) begin
    res_t want;
    int   i;
    if (!rst_n) begin
      for (i = 0; i < CELLS; i++) begin
        grid[i] = CELL_UNKNOWN;
      end
      beam_count = '0;
      win_lo     = RANGE_MIN_RST;
      win_hi     = RANGE_MAX_RST;
      ang_base   = ANGLE_START_RST;
      ang_incr   = ANGLE_STEP_RST;
      row_bias   = X_OFFSET_RST;
      col_bias   = Y_OFFSET_RST;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_RANGE_MIN:   win_lo   = cfg_wdata;
          REG_RANGE_MAX:   win_hi   = cfg_wdata;
          REG_ANGLE_START: ang_base = cfg_wdata;
          REG_ANGLE_STEP:  ang_incr = cfg_wdata;
          REG_X_OFFSET:    row_bias = cfg_wdata;
          REG_Y_OFFSET:    col_bias = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(predict_reading(in_mon.range_sample, in_mon.scan_start));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result word arrived with nothing expected");
          n_err++;
        end else begin
          want = expected_q.pop_front();
          check_field("cell_written", want.cell_written, out_mon.cell_written);
          check_field("out_of_map", want.out_of_map, out_mon.out_of_map);
          check_field("cell_index", want.cell_index, out_mon.cell_index);
          check_field("cell_value", want.cell_value, out_mon.cell_value);
        end
      end
    end
    errors        <= n_err;
    pending       <= expected_q.size();
    cells_hit     <= n_hit;
    off_grid      <= n_off;
    out_of_window <= n_skip;
    at_ceiling    <= n_ceil;
  end

endmodule

// File: tb/tb.sv
// Top of the occupancy grid testbench: clock, reset, register writes, reading stream, verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsog_pkg::*;

  localparam int ROWS           = 64;
  localparam int COLS           = 128;
  localparam int SINE_BITS      = 10;
  localparam int WATCHDOG_LIMIT = 40000;  // clearing pass after reset writes all 8192 map cells with no word accepted

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   send_gap_pct = 0;
  int                   stall_pct = 0;
  int                   quiet_cycles = 0;
  int                   readings = 0;
  logic [15:0]          win_lo, win_hi;
  int                   mismatches, pending, cells_hit, off_grid, out_of_window, at_ceiling;

  lsog_in_if  in_ch ();
  lsog_out_if out_ch ();

  laser_scan_occupancy_grid_update_core #(
    .GRID_ROWS(ROWS), .GRID_COLS(COLS), .SINE_TABLE_BITS(SINE_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  lsog_checker #(.ROWS(ROWS), .COLS(COLS), .SINE_BITS(SINE_BITS)) chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .errors(mismatches), .pending(pending), .cells_hit(cells_hit), .off_grid(off_grid),
    .out_of_window(out_of_window), .at_ceiling(at_ceiling)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_pace(input pace_e pace);
    case (pace)
      PACE_NONE:     begin send_gap_pct = 0;  stall_pct <= 0;  end
      PACE_SENDER:   begin send_gap_pct = 54; stall_pct <= 0;  end
      PACE_RECEIVER: begin send_gap_pct = 0;  stall_pct <= 54; end
      default:       begin send_gap_pct = 6;  stall_pct <= 6;  end
    endcase
  endtask

  task automatic push(input logic [15:0] rng, input logic first);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.range_sample <= rng;
    in_ch.scan_start   <= first;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    readings++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // waits until the core is empty, then loads all six registers plus the unmapped indexes
  task automatic program_regs(input logic [15:0] lo, hi, a0, da, xb, yb);
    drain();
    win_lo = lo;
    win_hi = hi;
    write_reg(REG_RANGE_MIN, lo);
    write_reg(REG_RANGE_MAX, hi);
    write_reg(REG_ANGLE_START, a0);
    write_reg(REG_ANGLE_STEP, da);
    write_reg(REG_X_OFFSET, xb);
    write_reg(REG_Y_OFFSET, yb);
    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // mostly inside the range window, some on its bounds, some anywhere
  function automatic logic [15:0] pick_range();
    int unsigned roll;
    int          lo, hi;
    roll = $urandom_range(99);
    lo   = win_lo;
    hi   = win_hi;
    if (roll < 8) begin
      case ($urandom_range(3))
        0:       return 16'(lo);
        1:       return 16'(hi);
        2:       return 16'(lo + 1);
        default: return 16'(hi - 1);
      endcase
    end else if (roll < 25 || hi <= lo + 1) begin
      return 16'($urandom_range(65535));
    end
    return 16'($urandom_range(hi - 1, lo + 1));
  endfunction

  function automatic logic [15:0] corner();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return 16'hFFFE;
      default: return 16'hFFFF;
    endcase
  endfunction

  // scans of random length; a few start without a scan_start or restart midway
  task automatic run_scans(input int n_items, input int max_len);
    int sent, len, i;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, max_len);
      for (i = 0; i < len && sent < n_items; i++) begin
        push(pick_range(), (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    int          p;
    logic [15:0] lo;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= '0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.range_sample <= '0;
    in_ch.scan_start   <= 1'b0;
    win_lo = RANGE_MIN_RST;
    win_hi = RANGE_MAX_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);

    // reset register values: beam at angle zero, bounds of the range window
    set_pace(PACE_NONE);
    push(16'd0, 1'b1);
    push(16'hFFFF, 1'b0);
    push(16'd1, 1'b0);
    push(16'd1, 1'b0);
    push(16'd256, 1'b0);
    push(16'hFFFE, 1'b0);
    push(16'h8000, 1'b1);
    push(16'h5555, 1'b0);
    push(16'hAAAA, 1'b0);

    // empty windows: equal bounds, then low bound above high bound
    program_regs(16'd100, 16'd100, 16'd0, 16'd0, 16'd256, 16'd1280);
    push(16'd100, 1'b1);
    push(16'd101, 1'b0);
    program_regs(16'hFFFF, 16'h0000, 16'd0, 16'd0, 16'd256, 16'd1280);
    push(16'h8000, 1'b1);

    // beams alternate +90 / -90 degrees: rows just below zero truncate to row zero
    program_regs(16'd0, 16'hFFFF, 16'h4000, 16'h8000, 16'd128, 16'd1280);
    push(16'd256, 1'b1);
    push(16'd256, 1'b0);
    push(16'd384, 1'b0);
    push(16'd640, 1'b0);

    // register extremes, angle sum wrapping
    program_regs(16'd0, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    push(16'h0001, 1'b1);
    push(16'hFFFE, 1'b0);
    push(16'h7FFF, 1'b0);
    program_regs(16'd0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
    push(16'd300, 1'b1);
    push(16'h4000, 1'b0);

    for (p = 0; p < 8; p++) begin
      set_pace(pace_e'(p % 4));
      case (p)
        4: begin
          // fixed beam angle, narrow window: a few cells driven to the ceiling
          lo = 16'($urandom_range(200, 6000));
          program_regs(lo, lo + 16'd40, 16'($urandom), 16'd0, 16'd8192, 16'd16384);
        end
        6: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
        7: program_regs(corner(), corner(), corner(), corner(), corner(), corner());
        default: program_regs(16'($urandom_range(0, 300)), 16'($urandom_range(3000, 9000)),
                              16'($urandom),
                              $urandom_range(1) ? 16'($urandom_range(0, 4095) - 2048)
                                                : 16'($urandom),
                              16'(7168 + $urandom_range(0, 2048)),
                              16'(14336 + $urandom_range(0, 4096)));
      endcase
      run_scans((p == 4) ? 300 : 220, 40);
    end

    drain();
    repeat (16) @(posedge clk);
    $display("Run covered %0d readings: %0d cells written (%0d clamped at full), %0d off the map,",
             readings, cells_hit, at_ceiling, off_grid);
    $display("%0d outside the range window; empty windows, register extremes, all pacings.",
             out_of_window);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
